>>> rtl/core/assert_macros.svh
// Assertion macros shared by the framer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sphf_pkg.sv
// Types and constants of the space packet header framer.
`default_nettype none
package sphf_pkg;

   localparam int BUFFER_CAPACITY = 1024;
   localparam int FILL_W = $clog2(BUFFER_CAPACITY + 1);
   localparam int OFFSET_W = 10;
   localparam int IDX_W = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [31:0] TC_LIMIT = 32'd3600000000;
   localparam logic [15:0] LEN_MARK = 16'hDEAD;
   localparam logic [15:0] LEN_BIAS = 16'd7;
   localparam logic [1:0] GROUP_FLAGS = 2'b11;
   localparam logic [OFFSET_W-1:0] LEN_OFF_HI = OFFSET_W'(4);
   localparam logic [OFFSET_W-1:0] LEN_OFF_LO = OFFSET_W'(5);

   localparam logic [IDX_W-1:0] LAST_IDX_ONE = IDX_W'(0);
   localparam logic [IDX_W-1:0] LAST_IDX_FIN = IDX_W'(1);
   localparam logic [IDX_W-1:0] LAST_IDX_HDR = IDX_W'(5);
   localparam logic [IDX_W-1:0] LAST_IDX_SEC = IDX_W'(9);

   typedef struct packed {
      logic [1:0]  mode;
      logic [10:0] apid;
      logic        use_sequence;
      logic [31:0] timecode;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] write_offset;
      logic [7:0]          write_byte;
      logic                refused;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [10:0]      apid;
      logic             use_sequence;
      logic             sec;
      logic [31:0]      timecode;
      logic [7:0]       data_byte;
      logic [IDX_W-1:0] last_idx;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/core/space_packet_header_framer_unit.sv
// Top level of the space packet header framer.
// Each item becomes byte writes into an external packet buffer, one write per
// clock at the back end's output register when not stalled: an append item makes
// one write, a finish item two, a start item six, or ten when the timecode is
// sent. The front end classifies items into a two-entry command queue, so appends
// stream at the same rate and a new item is taken while earlier writes are still
// going out; req_stall rises only when that queue is full. Unused mode 3 is taken
// and dropped. A refused write (buffer full) ends its item's writes.
`default_nettype none
module space_packet_header_framer_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sphf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sphf_pkg::rsp_type      rsp_data
);

   logic queue_full;
   logic push;
   logic pop;
   logic head_valid;
   sphf_pkg::cmd_type push_cmd;
   sphf_pkg::cmd_type head_cmd;

   sphf_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   sphf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   sphf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/core/sphf_front.sv
// Front end: accepts items, drops unused codes and classifies the rest into commands.
`default_nettype none
module sphf_front (
   input  wire logic             req_valid,
   input  wire sphf_pkg::req_type req_data,
   output logic                  req_stall,
   input  wire logic             queue_full,
   output logic                  push,
   output sphf_pkg::cmd_type     cmd
);

   logic sec;

   always_comb begin
      sec = req_data.timecode < sphf_pkg::TC_LIMIT;
      req_stall = queue_full;
      push = req_valid && !queue_full && (req_data.mode != sphf_pkg::MODE_NONE);
      cmd.kind = req_data.mode;
      cmd.apid = req_data.apid;
      cmd.use_sequence = req_data.use_sequence;
      cmd.sec = sec;
      cmd.timecode = req_data.timecode;
      cmd.data_byte = req_data.data_byte;
      case (req_data.mode)
         sphf_pkg::MODE_START: begin
            cmd.last_idx = sec ? sphf_pkg::LAST_IDX_SEC : sphf_pkg::LAST_IDX_HDR;
         end
         sphf_pkg::MODE_FINISH: begin
            cmd.last_idx = sphf_pkg::LAST_IDX_FIN;
         end
         default: begin
            cmd.last_idx = sphf_pkg::LAST_IDX_ONE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/sphf_queue.sv
// Command queue between front and back end.
`default_nettype none
`include "assert_macros.svh"
module sphf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sphf_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output sphf_pkg::cmd_type      head_cmd
);

   sphf_pkg::cmd_type entry_ff [sphf_pkg::QUEUE_DEPTH];
   logic [sphf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sphf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sphf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_pop;

   always_comb begin
      full = count_ff == sphf_pkg::QCNT_W'(sphf_pkg::QUEUE_DEPTH);
      head_valid = count_ff != '0;
      head_cmd = entry_ff[rd_ptr_ff];
      do_pop = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sphf_pkg::QPTR_W'(sphf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sphf_pkg::QPTR_W'(sphf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_IMPLIES(a_no_overflow, clock, reset, full, !push, "push into full queue")
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1,
      count_ff <= sphf_pkg::QCNT_W'(sphf_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule
`default_nettype wire

>>> rtl/core/sphf_back.sv
// Back end: expands commands into byte writes, tracks fill count and sequence count.
`default_nettype none
`include "assert_macros.svh"
module sphf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire sphf_pkg::cmd_type head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sphf_pkg::rsp_type      rsp_data
);

   logic [sphf_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [13:0] seq_ff, seq_in;
   logic [sphf_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   sphf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic issue;
   logic full;
   logic is_last;
   logic [31:0] fill_ext;
   logic [15:0] len;
   logic [13:0] seqv;
   logic [7:0] hdr_byte;
   logic [7:0] cur_byte;

   always_comb begin
      issue = head_valid && (!rsp_valid_ff || !rsp_stall);
      full = fill_ff >= sphf_pkg::FILL_W'(sphf_pkg::BUFFER_CAPACITY);
      is_last = idx_ff == head_cmd.last_idx;
      fill_ext = 32'(fill_ff);
      len = fill_ext[15:0] - sphf_pkg::LEN_BIAS;
      seqv = head_cmd.use_sequence ? seq_ff : 14'd0;
      case (idx_ff)
         4'd0: hdr_byte = {4'd0, head_cmd.sec, head_cmd.apid[10:8]};
         4'd1: hdr_byte = head_cmd.apid[7:0];
         4'd2: hdr_byte = {sphf_pkg::GROUP_FLAGS, seqv[13:8]};
         4'd3: hdr_byte = seqv[7:0];
         4'd4: hdr_byte = sphf_pkg::LEN_MARK[15:8];
         4'd5: hdr_byte = sphf_pkg::LEN_MARK[7:0];
         4'd6: hdr_byte = head_cmd.timecode[31:24];
         4'd7: hdr_byte = head_cmd.timecode[23:16];
         4'd8: hdr_byte = head_cmd.timecode[15:8];
         default: hdr_byte = head_cmd.timecode[7:0];
      endcase
      cur_byte = (head_cmd.kind == sphf_pkg::MODE_APPEND) ? head_cmd.data_byte : hdr_byte;

      pop = 1'b0;
      fill_in = fill_ff;
      seq_in = seq_ff;
      idx_in = idx_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (issue) begin
         rsp_valid_in = 1'b1;
         if (head_cmd.kind == sphf_pkg::MODE_FINISH) begin
            rsp_data_in.write_offset = is_last ? sphf_pkg::LEN_OFF_LO : sphf_pkg::LEN_OFF_HI;
            rsp_data_in.write_byte = is_last ? len[7:0] : len[15:8];
            rsp_data_in.refused = 1'b0;
            rsp_data_in.last = is_last;
            if (is_last) begin
               fill_in = '0;
            end
         end else begin
            rsp_data_in.write_offset = fill_ext[sphf_pkg::OFFSET_W-1:0];
            rsp_data_in.write_byte = cur_byte;
            rsp_data_in.refused = full;
            rsp_data_in.last = full || is_last;
            if (!full) begin
               fill_in = fill_ff + 1'b1;
               if (is_last && head_cmd.kind == sphf_pkg::MODE_START &&
                   head_cmd.use_sequence) begin
                  seq_in = seq_ff + 1'b1;
               end
            end
         end
         if (rsp_data_in.last) begin
            pop = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         fill_ff <= '0;
         seq_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         seq_ff <= seq_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `ASSERT_IMPLIES(a_fill_cap, clock, reset, 1'b1,
      fill_ff <= sphf_pkg::FILL_W'(sphf_pkg::BUFFER_CAPACITY), "fill count above capacity")
   `ASSERT_IMPLIES(a_idx_range, clock, reset, head_valid,
      idx_ff <= head_cmd.last_idx, "write index beyond command length")
   `ASSERT_NEXT(a_finish_clears, clock, reset,
      issue && head_cmd.kind == sphf_pkg::MODE_FINISH && is_last,
      fill_ff == '0, "fill count not cleared after finish")
   `ASSERT_NEXT(a_refused_holds, clock, reset, issue && full &&
      head_cmd.kind != sphf_pkg::MODE_FINISH,
      $stable(fill_ff) && $stable(seq_ff), "refused write changed state")

endmodule
`default_nettype wire
